### sv/fir_pkg.sv
`default_nettype none

package fir_pkg;

  localparam int FIR_TAPS_DEF = 95;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int IDX_W        = 7;
  localparam int FRAC_W       = 5;

  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(15);

  // request action codes
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } fir_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } fir_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_state_t;

endpackage

`default_nettype wire

### sv/fir_filter_direct_form.sv
`default_nettype none

// Direct-form FIR filter, 16-bit mono audio, TAPS taps. A filter request
// writes its sample into a circular delay-line memory and then runs one
// multiply-accumulate per tap, reading one sample and one coefficient per
// cycle from two single-read-port memories; the exact sum is shifted right
// by cfg_data's fraction-bit count (floor) and saturated to 16 bits, with
// clipped set when saturation acts. A filter request goes through RUN (one
// tap per cycle through the memory read port), DRAIN (until the read and
// multiply stages are empty) and DONE, where the shift/saturate result
// loads once the output slot is free; a coefficient-write request gives no
// result. A pending result sits in its own output register, so the next
// request is taken while it waits. Writes with coef_index >= TAPS are
// dropped. The delay line reads as zero after reset through a fill count;
// there is no clearing pass. Coefficients must be written before use.
module fir_filter_direct_form #(
  parameter int TAPS = fir_pkg::FIR_TAPS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire fir_pkg::fir_req_t              req,
  // result channel
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output fir_pkg::fir_rsp_t                   rsp,
  // fraction-bit register
  input  wire logic                           cfg_we,
  input  wire logic [fir_pkg::FRAC_W-1:0]     cfg_data
);

  import fir_pkg::*;

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;   // memory address width
  localparam int CW    = $clog2(TAPS + 1);                 // fill count, holds TAPS
  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;        // exact sum width

  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic [CW-1:0] FILL_MAX  = CW'(TAPS);

  // ---------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] delay_mem [TAPS];
  logic signed [COEF_W-1:0]   coef_mem  [TAPS];

  logic [FRAC_W-1:0] frac_bits;

  fir_state_t state, state_next;

  logic [AW-1:0] wr_ptr;     // next delay-line slot to write
  logic [AW-1:0] rd_ptr;     // delay-line slot of the tap being issued
  logic [AW-1:0] tap;        // tap being issued, also coefficient address
  logic [CW-1:0] fill_cnt;   // samples seen so far, saturates at TAPS

  // read stage
  logic                       s1_valid;
  logic                       s1_fill;
  logic signed [SAMPLE_W-1:0] d_q;
  logic signed [COEF_W-1:0]   c_q;
  // multiply stage
  logic                       s2_valid;
  logic signed [PROD_W-1:0]   prod;
  // accumulator
  logic signed [ACC_W-1:0]    acc;

  // control decode
  logic req_fire;
  logic sample_wr;
  logic coef_wr;
  logic issue;
  logic last_tap;
  logic pipe_empty;
  logic rsp_load;
  logic slot_free;

  logic [AW-1:0] coef_addr;

  assign req_fire   = req_valid && req_ready;
  assign sample_wr  = req_fire && (req.action == ACT_FILTER);
  assign coef_wr    = req_fire && (req.action == ACT_COEF) && (int'(req.coef_index) < TAPS);
  assign coef_addr  = AW'(req.coef_index);
  assign last_tap   = (tap == LAST_ADDR);
  assign pipe_empty = !s1_valid && !s2_valid;
  assign slot_free  = !rsp_valid || rsp_ready;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (sample_wr) state_next = ST_RUN;
      ST_RUN:   if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: if (pipe_empty) state_next = ST_DONE;
      ST_DONE:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    issue     = 1'b0;
    rsp_load  = 1'b0;
    unique case (state)
      ST_IDLE:  req_ready = 1'b1;
      ST_RUN:   issue     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  rsp_load  = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // fraction-bit register
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= FRAC_RESET;
    end else if (cfg_we) begin
      frac_bits <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Pointers and fill count
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      fill_cnt <= '0;
    end else if (sample_wr) begin
      wr_ptr <= (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + 1'b1;
      if (fill_cnt != FILL_MAX) fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // tap walk: newest sample first, walking back through the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      tap    <= '0;
      rd_ptr <= '0;
    end else if (sample_wr) begin
      tap    <= '0;
      rd_ptr <= wr_ptr;
    end else if (issue) begin
      tap    <= last_tap ? '0 : tap + 1'b1;
      rd_ptr <= (rd_ptr == '0) ? LAST_ADDR : rd_ptr - 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Memories. Writes happen only in IDLE and reads only in RUN, so the
  // sequencer keeps accesses to one entry from overlapping.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (sample_wr) delay_mem[wr_ptr] <= req.sample;
    if (issue)     d_q <= delay_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (coef_wr) coef_mem[coef_addr] <= req.coef_value;
    if (issue)   c_q <= coef_mem[tap];
  end

  // ---------------------------------------------------------------------
  // MAC pipeline: read -> multiply -> accumulate
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // taps older than the fill count read as the reset value, zero
  always_ff @(posedge clk) begin
    if (issue) s1_fill <= (CW'(tap) < fill_cnt);
    if (s1_valid) begin
      if (s1_fill) prod <= d_q * c_q;
      else prod <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_wr) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // ---------------------------------------------------------------------
  // Shift (floor) and saturate
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] shifted;
  logic                    hi_ones;
  logic                    hi_zeros;
  logic                    clip_pos;
  logic                    clip_neg;
  fir_rsp_t                rsp_next;

  always_comb begin
    shifted  = acc >>> frac_bits;
    hi_ones  = &shifted[ACC_W-1:SAMPLE_W-1];
    hi_zeros = ~|shifted[ACC_W-1:SAMPLE_W-1];
    clip_pos = !shifted[ACC_W-1] && !hi_zeros;
    clip_neg =  shifted[ACC_W-1] && !hi_ones;
    rsp_next.clipped = clip_pos || clip_neg;
    if (clip_pos) begin
      rsp_next.filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (clip_neg) begin
      rsp_next.filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      rsp_next.filtered = shifted[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) rsp <= rsp_next;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= FILL_MAX)
    else $error("fill count beyond tap count");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> pipe_empty)
    else $error("result formed with MAC pipeline busy");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && rsp_valid && !rsp_ready) |=> (state == ST_DONE))
    else $error("result overwrote a pending one");

  a_tap_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !last_tap) |=> (tap == $past(tap) + 1'b1))
    else $error("tap walk skipped a tap");

endmodule

`default_nettype wire
